[rtl/sau_pkg.sv]
package sau_pkg;

    localparam int DATA_W          = 32;
    localparam int REQ_W           = 3;
    localparam int COUNT_OUT_W     = 7;
    localparam int OPERANDS_NEEDED = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH = 3'd0,
        REQ_ADD  = 3'd1,
        REQ_SUB  = 3'd2,
        REQ_MUL  = 3'd3,
        REQ_DIV  = 3'd4,
        REQ_MOD  = 3'd5
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_ABOVE,
        CELL_FROM_BELOW
    } cell_mode_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
    } div_rsp_t;

endpackage

[rtl/sau_if.sv]
interface sau_req_if;
    logic                          valid;
    logic                          ready;
    logic [sau_pkg::REQ_W-1:0]     req_type;
    logic signed [sau_pkg::DATA_W-1:0] push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface sau_rsp_if;
    logic                               valid;
    logic                               ready;
    sau_pkg::status_t                   status;
    logic signed [sau_pkg::DATA_W-1:0]  top_value;
    logic [sau_pkg::COUNT_OUT_W-1:0]    stack_count;

    modport source (output valid, output status, output top_value, output stack_count,
                    input ready);
    modport sink   (input valid, input status, input top_value, input stack_count,
                    output ready);
endinterface

[rtl/sau_cell.sv]
module sau_cell (
    input  logic                          clk,
    input  sau_pkg::cell_mode_t           mode,
    input  logic [sau_pkg::DATA_W-1:0]    from_above,
    input  logic [sau_pkg::DATA_W-1:0]    from_below,
    output logic [sau_pkg::DATA_W-1:0]    value
);

    logic [sau_pkg::DATA_W-1:0] value_reg;
    logic [sau_pkg::DATA_W-1:0] value_next;

    always_comb
    begin
        case (mode)
            sau_pkg::CELL_FROM_ABOVE: value_next = from_above;
            sau_pkg::CELL_FROM_BELOW: value_next = from_below;
            default:                  value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

[rtl/sau_div.sv]
module sau_div (
    input  logic              clk,
    input  logic              rst_n,
    input  sau_pkg::div_cmd_t cmd,
    output sau_pkg::div_rsp_t rsp
);

    localparam int W    = sau_pkg::DATA_W;
    localparam int CNTW = $clog2(W);
    localparam logic [CNTW-1:0] LAST_STEP = CNTW'(W - 1);

    typedef enum logic {
        D_IDLE,
        D_RUN
    } div_state_t;

    div_state_t     state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]   rem_reg, rem_next;
    logic [W-1:0]   quo_reg, quo_next;
    logic [W-1:0]   den_reg, den_next;
    logic           qneg_reg, qneg_next;
    logic           rneg_reg, rneg_next;
    logic           done_reg, done_next;

    logic [W:0]     shifted;
    logic [W:0]     trial;
    logic [W-1:0]   dividend_mag;
    logic [W-1:0]   divisor_mag;

    always_comb
    begin
        dividend_mag = cmd.dividend[W-1] ? (~cmd.dividend + 1'b1) : cmd.dividend;
        divisor_mag  = cmd.divisor[W-1]  ? (~cmd.divisor + 1'b1)  : cmd.divisor;
        shifted      = {rem_reg, quo_reg[W-1]};
        trial        = shifted - {1'b0, den_reg};

        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        qneg_next  = qneg_reg;
        rneg_next  = rneg_reg;
        done_next  = 1'b0;

        unique case (state_reg)
            D_IDLE:
            begin
                if (cmd.start)
                begin
                    rem_next   = '0;
                    quo_next   = dividend_mag;
                    den_next   = divisor_mag;
                    qneg_next  = cmd.dividend[W-1] ^ cmd.divisor[W-1];
                    rneg_next  = cmd.dividend[W-1];
                    cnt_next   = '0;
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                rem_next = trial[W] ? shifted[W-1:0] : trial[W-1:0];
                quo_next = {quo_reg[W-2:0], ~trial[W]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            den_reg   <= '0;
            qneg_reg  <= 1'b0;
            rneg_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            den_reg   <= den_next;
            qneg_reg  <= qneg_next;
            rneg_reg  <= rneg_next;
            done_reg  <= done_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = qneg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign rsp.remainder = rneg_reg ? (~rem_reg + 1'b1) : rem_reg;

endmodule

[rtl/stack_arithmetic_unit_core.sv]
// Stack arithmetic unit.
// Requests arrive on the req channel (valid/ready): req_type selects push, add,
// sub, mul, div or mod; push_value is used by push only. Every accepted
// transaction yields exactly one transaction on the rsp channel carrying the
// status, the top entry after the request (zero when empty) and the entry count.
// Binary operations take the second entry as left operand, pop both and push
// the result; errors leave the stack untouched.
// The stack is a row of cells, top entry in cell 0; a push shifts the row down
// one cell, a binary operation shifts it up while cell 0 takes the result.
// Push and error cases go straight to the output register; add, sub and mul
// pass through the write-back state first; div and mod wait in the divide state
// for the divider, which produces one quotient bit per cycle, then write back.
// One request is worked on at a time; the next one is accepted once the previous
// result has reached the output register and the unit is back in idle.
// When rsp is stalled the output register holds its transaction; at most one
// further request is accepted and finished, then waits for the register.
// Reset empties the stack; no clearing pass is needed.
module stack_arithmetic_unit_core #(
    parameter int STACK_DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    sau_req_if.sink      req,
    sau_rsp_if.source    rsp
);

    localparam int W  = sau_pkg::DATA_W;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] NEEDED    = CW'(sau_pkg::OPERANDS_NEEDED);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_WB,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    sau_pkg::status_t                status_reg, status_next;
    logic [W-1:0]                    res_reg, res_next;
    logic                            is_mod_reg, is_mod_next;
    logic                            out_valid_reg, out_valid_next;
    sau_pkg::status_t                out_status_reg, out_status_next;
    logic [W-1:0]                    out_top_reg, out_top_next;
    logic [sau_pkg::COUNT_OUT_W-1:0] out_count_reg, out_count_next;

    logic [W-1:0]                    cell_value [STACK_DEPTH];
    sau_pkg::cell_mode_t             mode_head;
    sau_pkg::cell_mode_t             mode_tail;
    logic [W-1:0]                    head_in;
    logic [W-1:0]                    right_v;
    logic [W-1:0]                    left_v;
    logic [W-1:0]                    product;
    logic [CW+sau_pkg::COUNT_OUT_W-1:0] count_ext;
    logic                            accept;
    logic                            out_free;
    sau_pkg::div_cmd_t               div_cmd;
    sau_pkg::div_rsp_t               div_rsp;

    assign right_v  = cell_value[0];
    assign left_v   = cell_value[1];
    assign product  = left_v * right_v;
    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign count_ext = {{sau_pkg::COUNT_OUT_W{1'b0}}, count_reg};

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        res_next        = res_reg;
        is_mod_next     = is_mod_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_top_next    = out_top_reg;
        out_count_next  = out_count_reg;
        mode_head       = sau_pkg::CELL_HOLD;
        mode_tail       = sau_pkg::CELL_HOLD;
        head_in         = res_reg;
        div_cmd.start    = 1'b0;
        div_cmd.dividend = left_v;
        div_cmd.divisor  = right_v;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = sau_pkg::ST_OK;
                    state_next  = S_DONE;
                    unique case (req.req_type) inside
                        sau_pkg::REQ_PUSH:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                status_next = sau_pkg::ST_FULL;
                            end
                            else
                            begin
                                head_in    = req.push_value;
                                mode_head  = sau_pkg::CELL_FROM_ABOVE;
                                mode_tail  = sau_pkg::CELL_FROM_ABOVE;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        sau_pkg::REQ_ADD, sau_pkg::REQ_SUB, sau_pkg::REQ_MUL:
                        begin
                            if (count_reg < NEEDED)
                            begin
                                status_next = sau_pkg::ST_SHORT;
                            end
                            else
                            begin
                                state_next = S_WB;
                                case (req.req_type)
                                    sau_pkg::REQ_ADD: res_next = left_v + right_v;
                                    sau_pkg::REQ_SUB: res_next = left_v - right_v;
                                    default:          res_next = product;
                                endcase
                            end
                        end
                        sau_pkg::REQ_DIV, sau_pkg::REQ_MOD:
                        begin
                            if (count_reg < NEEDED)
                            begin
                                status_next = sau_pkg::ST_SHORT;
                            end
                            else if (right_v == '0)
                            begin
                                status_next = sau_pkg::ST_DIVZERO;
                            end
                            else
                            begin
                                div_cmd.start = 1'b1;
                                is_mod_next   = (req.req_type == sau_pkg::REQ_MOD);
                                state_next    = S_DIV;
                            end
                        end
                        default: status_next = sau_pkg::ST_OK;
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_next   = is_mod_reg ? div_rsp.remainder : div_rsp.quotient;
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                head_in    = res_reg;
                mode_head  = sau_pkg::CELL_FROM_ABOVE;
                mode_tail  = sau_pkg::CELL_FROM_BELOW;
                count_next = count_reg - 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_top_next    = (count_reg != '0) ? right_v : '0;
                    out_count_next  = count_ext[sau_pkg::COUNT_OUT_W-1:0];
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            status_reg     <= sau_pkg::ST_OK;
            res_reg        <= '0;
            is_mod_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= sau_pkg::ST_OK;
            out_top_reg    <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            status_reg     <= status_next;
            res_reg        <= res_next;
            is_mod_reg     <= is_mod_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_top_reg    <= out_top_next;
            out_count_reg  <= out_count_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < STACK_DEPTH; i++)
        begin : g_cell
            sau_cell u_cell (
                .clk        (clk),
                .mode       ((i == 0) ? mode_head : mode_tail),
                .from_above ((i == 0) ? head_in : cell_value[(i == 0) ? 0 : i - 1]),
                .from_below (cell_value[(i == STACK_DEPTH - 1) ? i : i + 1]),
                .value      (cell_value[i])
            );
        end
    endgenerate

    sau_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.top_value   = out_top_reg;
    assign rsp.stack_count = out_count_reg;

endmodule

[rtl/sau_checker.sv]
module sau_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  logic                                req_ready,
    input  logic                                rsp_valid,
    input  logic                                rsp_ready,
    input  sau_pkg::status_t                    rsp_status,
    input  logic [sau_pkg::DATA_W-1:0]          rsp_top_value,
    input  logic [sau_pkg::COUNT_OUT_W-1:0]     rsp_stack_count
);

    localparam logic [sau_pkg::COUNT_OUT_W-1:0] FULL_CNT =
        sau_pkg::COUNT_OUT_W'(STACK_DEPTH);

    logic [1:0] pending_reg, pending_next;
    logic       acc_in;
    logic       acc_out;

    assign acc_in  = req_valid && req_ready;
    assign acc_out = rsp_valid && rsp_ready;

    always_comb
    begin
        pending_next = pending_reg + {1'b0, acc_in} - {1'b0, acc_out};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_no_spurious_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (!rsp_valid || pending_reg != 2'd0) && pending_reg != 2'd3)
        else $error("response without an outstanding request");

    a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stack_count == '0 && STACK_DEPTH < 128 |-> rsp_top_value == '0)
        else $error("empty stack reports a nonzero top value");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == sau_pkg::ST_FULL |-> rsp_stack_count == FULL_CNT)
        else $error("stack full reported below capacity");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_top_value) && $stable(rsp_stack_count))
        else $error("stalled response changed");

endmodule

bind stack_arithmetic_unit_core sau_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_sau_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_top_value   (rsp.top_value),
    .rsp_stack_count (rsp.stack_count)
);
